/* sv/slep_pkg.sv */
package slep_pkg;

   // Default ring depth in bytes
   localparam int POOL_DEPTH_DEFAULT = 128;

   // Opcode values of the request beat
   localparam logic OP_FEED = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Bits kept from each axis, bits in one packed group
   localparam int AXIS_BITS  = 2;
   localparam int GROUP_BITS = 3 * AXIS_BITS;

   // Command passed from the packer to the pool side
   typedef struct packed {
      logic       is_read;
      logic [7:0] data;
   } cmd_type;

endpackage

/* sv/slep_ram.sv */
module slep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port that holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/slep_front.sv */
module slep_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic               req_burst_start,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic               q_full,
   output logic               q_push,
   output slep_pkg::cmd_type  q_cmd
);

   import slep_pkg::*;

   logic [7:0]            partial_ff, partial_in;
   logic [2:0]            offset_ff, offset_in;
   logic [7:0]            base_partial;
   logic [2:0]            base_offset;
   logic [GROUP_BITS-1:0] group;
   logic [13:0]           word;
   logic                  byte_done;
   logic                  accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Pack the low axis bits, x highest, LSB-first into the partial byte
   always_comb begin
      group        = {req_accel_x[1:0], req_accel_y[1:0], req_accel_z[1:0]};
      base_partial = req_burst_start ? 8'd0 : partial_ff;
      base_offset  = req_burst_start ? 3'd0 : offset_ff;
      word         = {6'd0, base_partial} | ({8'd0, group} << base_offset);
      byte_done    = (base_offset >= 3'd2);
      if (byte_done) begin
         partial_in = {2'd0, word[13:8]};
         offset_in  = base_offset - 3'd2;
      end else begin
         partial_in = word[7:0];
         offset_in  = base_offset + 3'd6;
      end
   end

   // Reads always go to the pool side; feeds only when a byte completes
   always_comb begin
      q_cmd.is_read = (req_opcode == OP_READ);
      q_cmd.data    = word[7:0];
      q_push        = accept && ((req_opcode == OP_READ) || byte_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 8'd0;
         offset_ff  <= 3'd0;
      end else if (accept && (req_opcode == OP_FEED)) begin
         partial_ff <= partial_in;
         offset_ff  <= offset_in;
      end
   end

endmodule

/* sv/slep_cmd_queue.sv */
module slep_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  slep_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output slep_pkg::cmd_type head_cmd
);

   import slep_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_sel_ff, rd_sel_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_sel_ff];

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_sel_ff] <= push_cmd;
      end
   end

   // Two-entry ring control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_sel_ff <= !wr_sel_ff;
         end
         if (pop) begin
            rd_sel_ff <= !rd_sel_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* sv/slep_back.sv */
module slep_back #(
   parameter int POOL_DEPTH = slep_pkg::POOL_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  slep_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_random_byte,
   output logic              rsp_byte_valid,
   output logic [7:0]        rsp_pool_level
);

   import slep_pkg::*;

   localparam int PTR_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             byte_valid_ff, byte_valid_in;
   logic [7:0]       level_ff, level_in;
   logic [CNT_W+7:0] level_ext;
   logic             out_free;
   logic             do_push, do_read, pool_full, pool_empty;
   logic [7:0]       ram_rd_data;
   logic [PTR_W-1:0] rd_ptr_next, wr_ptr_next;

   // Output slot is free when empty or its beat leaves this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign q_pop      = q_valid && (!q_cmd.is_read || out_free);
   assign do_push    = q_pop && !q_cmd.is_read;
   assign pool_full  = (fill_ff == CNT_W'(POOL_DEPTH));
   assign pool_empty = (fill_ff == '0);
   assign do_read    = q_pop && q_cmd.is_read && !pool_empty;

   assign rd_ptr_next = (rd_ptr_ff == PTR_W'(POOL_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_ptr_next = (wr_ptr_ff == PTR_W'(POOL_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;

   slep_ram #(
      .WIDTH (8),
      .DEPTH (POOL_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ptr_ff),
      .wr_data (q_cmd.data),
      .rd_en   (do_read),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Ring pointers, fill count and response slot
   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      byte_valid_in = byte_valid_ff;
      level_in      = level_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_next;
         if (pool_full) begin
            // overwrite the oldest byte
            rd_ptr_in = rd_ptr_next;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      level_ext = {8'd0, fill_ff - 1'b1};
      if (q_pop && q_cmd.is_read) begin
         rsp_valid_in = 1'b1;
         if (pool_empty) begin
            byte_valid_in = 1'b0;
            level_in      = 8'd0;
         end else begin
            byte_valid_in = 1'b1;
            level_in      = level_ext[7:0];
            rd_ptr_in     = rd_ptr_next;
            fill_in       = fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         byte_valid_ff <= 1'b0;
         level_ff      <= 8'd0;
      end else begin
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
         byte_valid_ff <= byte_valid_in;
         level_ff      <= level_in;
      end
   end

   // RAM read register holds while the beat waits
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_valid  = byte_valid_ff;
   assign rsp_pool_level  = level_ff;
   assign rsp_random_byte = byte_valid_ff ? ram_rd_data : 8'd0;

endmodule

/* sv/sensor_lsb_entropy_pool.sv */
// Entropy pool fed from 3-axis accelerometer samples.
// Request channel (req_*): opcode feed packs the two low bits of x, y and z
// into a 6-bit group, LSB-first into bytes; each full byte goes into a ring
// of POOL_DEPTH bytes, overwriting the oldest when full. burst_start clears
// the partial byte first. Opcode read pops the oldest byte.
// Response channel (rsp_*): one beat per read, none per feed. An empty pool
// answers byte_valid = 0, random_byte = 0, pool_level = 0.
// Path: a read beat passes the combinational packer, the two-entry
// command queue, then the pool RAM read port into the response register.
// Throughput: one request beat per cycle while req_ready is high, set by the
// single RAM port pair: one write or one read issued per cycle on the pool side.
// Reset clears the packer, pointers, fill count and the response slot; the
// pool RAM itself is not cleared and needs no sweep.
// When the receiver stalls, a waiting read holds the queue head and commands
// behind it wait too; feeds that finish no byte are still taken, and
// req_ready drops once the queue holds two commands.
module sensor_lsb_entropy_pool #(
   parameter int POOL_DEPTH = slep_pkg::POOL_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic               req_burst_start,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_random_byte,
   output logic               rsp_byte_valid,
   output logic [7:0]         rsp_pool_level
);

   import slep_pkg::*;

   logic    q_full, q_push, q_pop, q_valid;
   cmd_type push_cmd, head_cmd;

   slep_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_burst_start (req_burst_start),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   slep_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   slep_back #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (head_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_byte (rsp_random_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_pool_level  (rsp_pool_level)
   );

endmodule

/* dv/tb_sensor_lsb_entropy_pool.sv */
module tb_sensor_lsb_entropy_pool;
   import slep_pkg::*;

   localparam int DEPTH       = POOL_DEPTH_DEFAULT;
   localparam int ITEM_TARGET = 1250;
   localparam int CALM_TAIL   = 150;
   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 8;

   // Expected response beat
   typedef struct packed {
      logic [7:0] random_byte;
      logic       byte_valid;
      logic [7:0] pool_level;
   } pool_reply_type;

   // One row of the directed table; typed rows carry their own answer
   typedef struct packed {
      logic           op;
      logic           burst;
      logic [15:0]    ax;
      logic [15:0]    ay;
      logic [15:0]    az;
      logic           typed;
      pool_reply_type reply;
   } stim_row_type;

   typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED, PH_BURSTY} phase_mode_type;

   localparam pool_reply_type NO_REPLY   = '{8'h00, 1'b0, 8'd0};
   localparam int             DIRECTED_N = 18;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      // empty pool right after reset, burst flag and accel ignored on a read
      '{OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, NO_REPLY},
      '{OP_READ, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NO_REPLY},
      // two all-ones groups make one 0xFF byte
      '{OP_FEED, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
      '{OP_FEED, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, NO_REPLY},
      '{OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'hFF, 1'b1, 8'd0}},
      '{OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, NO_REPLY},
      // burst start drops the leftover nibble; two zero groups give 0x00
      '{OP_FEED, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPLY},
      '{OP_FEED, 1'b0, 16'h8000, 16'h8000, 16'h8000, 1'b0, NO_REPLY},
      '{OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'h00, 1'b1, 8'd0}},
      // mixed axis bits, then a burst start in the middle of a byte
      '{OP_FEED, 1'b0, 16'h0001, 16'h0002, 16'h0003, 1'b0, NO_REPLY},
      '{OP_FEED, 1'b0, 16'h8001, 16'h7FFE, 16'hFFFD, 1'b0, NO_REPLY},
      '{OP_FEED, 1'b0, 16'h0002, 16'h0001, 16'h0000, 1'b0, NO_REPLY},
      '{OP_FEED, 1'b1, 16'h0003, 16'h8000, 16'h7FFF, 1'b0, NO_REPLY},
      '{OP_FEED, 1'b0, 16'hFFFE, 16'h0001, 16'h8002, 1'b0, NO_REPLY},
      '{OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPLY},
      '{OP_READ, 1'b1, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, NO_REPLY},
      '{OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPLY},
      '{OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPLY}
   };

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic               req_opcode      = OP_FEED;
   logic               req_burst_start = 1'b0;
   logic signed [15:0] req_accel_x     = '0;
   logic signed [15:0] req_accel_y     = '0;
   logic signed [15:0] req_accel_z     = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [7:0]         rsp_random_byte;
   logic               rsp_byte_valid;
   logic [7:0]         rsp_pool_level;

   // Shadow of the pool
   logic [7:0]  ring_bytes [DEPTH];
   logic [6:0]  ring_head;
   int unsigned ring_level;
   logic [7:0]  pack_byte;
   logic [2:0]  pack_offset;

   pool_reply_type pending_replies [$];
   bit             idle_on = 1'b1;
   int             error_count;
   int             quiet_cycles;
   int             items_sent;
   int             feed_count, burst_count, overwrite_count, read_count, empty_read_count;

   sensor_lsb_entropy_pool #(.POOL_DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_burst_start (req_burst_start),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_byte (rsp_random_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_pool_level  (rsp_pool_level)
   );

   always #4 clock = ~clock;

   // Pool behavior for one accepted beat; a read yields one reply
   task automatic pool_model_step(input logic op, input logic burst,
                                  input logic [15:0] ax, input logic [15:0] ay,
                                  input logic [15:0] az,
                                  output bit has_reply, output pool_reply_type reply);
      logic [5:0]  group;
      logic [15:0] merged;
      logic [6:0]  slot;
      has_reply = 1'b0;
      reply     = NO_REPLY;
      if (op == OP_FEED) begin
         feed_count++;
         if (burst) begin
            burst_count++;
            pack_byte   = 8'h00;
            pack_offset = 3'd0;
         end
         group  = {ax[1:0], ay[1:0], az[1:0]};
         merged = {8'h00, pack_byte} | ({10'h000, group} << pack_offset);
         if (pack_offset >= 3'd2) begin
            // byte complete: push it, overwriting the oldest when full
            slot = ring_head + ring_level[6:0];
            ring_bytes[slot] = merged[7:0];
            if (ring_level == DEPTH) begin
               ring_head++;
               overwrite_count++;
            end else begin
               ring_level++;
            end
            pack_byte   = merged[15:8];
            pack_offset = pack_offset - 3'd2;
         end else begin
            pack_byte   = merged[7:0];
            pack_offset = pack_offset + 3'd6;
         end
      end else begin
         read_count++;
         has_reply = 1'b1;
         if (ring_level == 0) begin
            empty_read_count++;
         end else begin
            reply.random_byte = ring_bytes[ring_head];
            reply.byte_valid  = 1'b1;
            ring_head++;
            ring_level--;
            reply.pool_level  = ring_level[7:0];
         end
      end
   endtask

   // Present one request beat and hold it until accepted
   task automatic send_beat(input logic op, input logic burst,
                            input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] az,
                            input bit typed, input pool_reply_type typed_reply);
      bit             has_reply;
      pool_reply_type model_reply;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_burst_start <= burst;
      req_accel_x     <= ax;
      req_accel_y     <= ay;
      req_accel_z     <= az;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pool_model_step(op, burst, ax, ay, az, has_reply, model_reply);
      if (has_reply) pending_replies.push_back(typed ? typed_reply : model_reply);
      items_sent++;
   endtask

   // Hold off the sender until every read has been answered
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   // Receiver backpressure in random bursts
   initial begin
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // Response checker
   always @(posedge clock) begin
      pool_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response beat byte=%h valid=%b level=%0d",
                     $time, rsp_random_byte, rsp_byte_valid, rsp_pool_level);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_random_byte !== want.random_byte) begin
               $display("%0t: random_byte expected %h actual %h",
                        $time, want.random_byte, rsp_random_byte);
               error_count++;
            end
            if (rsp_byte_valid !== want.byte_valid) begin
               $display("%0t: byte_valid expected %b actual %b",
                        $time, want.byte_valid, rsp_byte_valid);
               error_count++;
            end
            if (rsp_pool_level !== want.pool_level) begin
               $display("%0t: pool_level expected %0d actual %0d",
                        $time, want.pool_level, rsp_pool_level);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      phase_mode_type mode;
      int             phase_len;
      int             phase_idx;
      int             feed_pct;
      int             burst_odds;
      logic           op;
      logic           burst;
      for (int i = 0; i < DEPTH; i++) ring_bytes[i] = 8'h00;
      ring_head        = '0;
      ring_level       = 0;
      pack_byte        = 8'h00;
      pack_offset      = 3'd0;
      error_count      = 0;
      quiet_cycles     = 0;
      items_sent       = 0;
      feed_count       = 0;
      burst_count      = 0;
      overwrite_count  = 0;
      read_count       = 0;
      empty_read_count = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[r]) begin
         send_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].burst, DIRECTED_ROWS[r].ax,
                   DIRECTED_ROWS[r].ay, DIRECTED_ROWS[r].az,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].reply);
      end
      wait_for_replies();

      // random phases: fill past full, drain past empty, mixed and bursty traffic
      phase_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         mode = phase_mode_type'($urandom_range(0, 3));
         if (phase_idx == 0) mode = PH_FILL;
         if (phase_idx == 1) mode = PH_DRAIN;
         case (mode)
            PH_FILL: begin
               phase_len = $urandom_range(200, 320); feed_pct = 97; burst_odds = 24;
            end
            PH_DRAIN: begin
               phase_len = $urandom_range(40, 180); feed_pct = 15; burst_odds = 16;
            end
            PH_MIXED: begin
               phase_len = $urandom_range(30, 120); feed_pct = 55; burst_odds = 12;
            end
            default: begin
               phase_len = $urandom_range(30, 120); feed_pct = 75; burst_odds = 3;
            end
         endcase
         for (int n = 0; n < phase_len && items_sent < ITEM_TARGET; n++) begin
            if (ITEM_TARGET - items_sent <= CALM_TAIL) idle_on = 1'b0;
            op    = ($urandom_range(0, 99) < feed_pct) ? OP_FEED : OP_READ;
            burst = (op == OP_FEED) ? ($urandom_range(0, burst_odds - 1) == 0)
                                    : logic'($urandom_range(0, 1));
            send_beat(op, burst, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      1'b0, NO_REPLY);
         end
         if (phase_idx == 0 || $urandom_range(0, 3) == 0) wait_for_replies();
         phase_idx++;
      end

      // drain and let the pipeline settle
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d feeds (%0d burst starts, %0d overwrites of a full pool)",
               feed_count, burst_count, overwrite_count);
      $display("and %0d reads (%0d on an empty pool); %0d mismatches",
               read_count, empty_read_count, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
